### rtl/mvna_pkg.sv
// Package for the mesh vertex normal accumulator.
// Payload structs, state enums and fixed arithmetic constants; no dependencies.
`default_nettype none

package mvna_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned VERTEX_DEPTH_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF   = 16;

  // Fixed field widths
  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 16;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned SUM_W = 32;

  // Fixed-point scaling: magnitudes are reduced below 2^MAG_BITS, unit is 2^UNIT_SHIFT
  localparam int unsigned MAG_BITS   = 30;
  localparam int unsigned UNIT_SHIFT = 14;
  localparam int unsigned QUO_W      = UNIT_SHIFT + 1;
  localparam int unsigned SQ_W       = 2 * MAG_BITS + 2;
  localparam int unsigned RT_W       = 64;
  localparam int unsigned LEN_W      = MAG_BITS + 2;
  localparam int unsigned DIV_W      = MAG_BITS + UNIT_SHIFT + 2;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_READ     = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   vertex_index;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic [IDX_W-1:0]   corner_a;
    logic [IDX_W-1:0]   corner_b;
    logic [IDX_W-1:0]   corner_c;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_vertex;
    logic [NRM_W-1:0]   normal_x;
    logic [NRM_W-1:0]   normal_y;
    logic [NRM_W-1:0]   normal_z;
    logic               zero_length;
  } out_t;

  // Result of the unit-length scaler
  typedef struct packed {
    logic                        done;
    logic                        zero;
    logic [2:0][NRM_W-1:0]       nrm;
  } unit_res_t;

  typedef enum logic [2:0] {
    U_IDLE, U_SHIFT, U_SQ, U_SQRT, U_DLOAD, U_DIV, U_DONE
  } unit_state_e;

  typedef enum logic [3:0] {
    T_CLEAR, T_IDLE, T_RDA, T_RDB, T_RDC, T_EDGE, T_REDUCE, T_CROSS,
    T_USTART, T_UWAIT, T_ACC_RD, T_ACC_WR, T_SUM_RD, T_SUM_START, T_SUM_WAIT, T_OUT
  } top_state_e;

endpackage

`default_nettype wire

### rtl/mvna_if.sv
// Valid/ready stream interfaces for the input and result channels.
// Depends on mvna_pkg for the payload structs.
`default_nettype none

interface mvna_in_if;
  import mvna_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mvna_out_if;
  import mvna_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/mvna_unit.sv
// Unit-length scaler: common shift, sum of squares, bitwise square root and
// restoring division to Q1.14, one step per cycle. Depends on mvna_pkg.
`default_nettype none

module mvna_unit
  import mvna_pkg::*;
#(
  parameter int unsigned VW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [VW-1:0] vec_i [3],
  output unit_res_t            res_o
);

  unit_state_e state_q, state_d;

  logic [VW-1:0]        mag_q [3];
  logic [2:0]           neg_q;
  logic [1:0]           cnt_q;
  logic [2*MAG_BITS-1:0] prod_q;
  logic [SQ_W-1:0]      acc_q;
  logic [RT_W-1:0]      x_q, r_q, bit_q;
  logic [DIV_W-1:0]     rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic [3:0]           step_q;
  logic [2:0][NRM_W-1:0] nrm_q;
  logic                 zero_q;

  logic                 over;
  logic [MAG_BITS-1:0]  m_sel;
  logic [RT_W-1:0]      rt_try;
  logic [LEN_W-1:0]     len;
  logic [DIV_W-1:0]     dsor;
  logic                 dsub;
  logic [QUO_W-1:0]     quo_nx;

  // Any magnitude still at or above the limit
  assign over = ((mag_q[0] >> MAG_BITS) != '0) || ((mag_q[1] >> MAG_BITS) != '0) ||
                ((mag_q[2] >> MAG_BITS) != '0);

  // Pick the component being squared or divided
  always_comb begin
    case (cnt_q)
      2'd0:    m_sel = mag_q[0][MAG_BITS-1:0];
      2'd1:    m_sel = mag_q[1][MAG_BITS-1:0];
      2'd2:    m_sel = mag_q[2][MAG_BITS-1:0];
      default: m_sel = '0;
    endcase
  end

  assign rt_try = r_q + bit_q;
  assign len    = r_q[LEN_W-1:0];
  assign dsor   = DIV_W'(len) << step_q;
  assign dsub   = (rem_q >= dsor);
  always_comb begin
    quo_nx = quo_q;
    if (dsub) begin
      quo_nx[step_q] = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE:  if (start_i) state_d = U_SHIFT;
      U_SHIFT: if (!over) state_d = U_SQ;
      U_SQ:    if (cnt_q == 2'd3) state_d = U_SQRT;
      U_SQRT:  if (bit_q == '0) state_d = (r_q == '0) ? U_DONE : U_DLOAD;
      U_DLOAD: state_d = U_DIV;
      U_DIV: begin
        if (step_q == 4'd0) state_d = (cnt_q == 2'd2) ? U_DONE : U_DLOAD;
      end
      U_DONE:  state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
          neg_q[i] <= vec_i[i][VW-1];
        end
        cnt_q <= 2'd0;
        acc_q <= '0;
      end
      U_SHIFT: begin
        if (over) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end
      end
      U_SQ: begin
        prod_q <= (2*MAG_BITS)'(m_sel) * (2*MAG_BITS)'(m_sel);
        if (cnt_q != 2'd0) acc_q <= acc_q + SQ_W'(prod_q);
        cnt_q <= cnt_q + 2'd1;
        x_q   <= RT_W'(acc_q) + RT_W'(prod_q);
        r_q   <= '0;
        bit_q <= RT_W'(1) << (RT_W - 2);
      end
      U_SQRT: begin
        if (bit_q != '0) begin
          if (x_q >= rt_try) begin
            x_q <= x_q - rt_try;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          zero_q <= (r_q == '0);
          nrm_q  <= '0;
          cnt_q  <= 2'd0;
        end
      end
      U_DLOAD: begin
        rem_q  <= DIV_W'({m_sel, UNIT_SHIFT'(0)}) + DIV_W'(len >> 1);
        quo_q  <= '0;
        step_q <= 4'(UNIT_SHIFT);
      end
      U_DIV: begin
        if (dsub) rem_q <= rem_q - dsor;
        quo_q  <= quo_nx;
        step_q <= step_q - 4'd1;
        if (step_q == 4'd0) begin
          nrm_q[cnt_q] <= neg_q[cnt_q] ? -NRM_W'(quo_nx) : NRM_W'(quo_nx);
          cnt_q        <= cnt_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign res_o.done = (state_q == U_DONE);
  assign res_o.zero = zero_q;
  assign res_o.nrm  = nrm_q;

endmodule

`default_nettype wire

### rtl/mesh_vertex_normal_accumulator.sv
// Top level of the mesh vertex normal accumulator: position and normal-sum
// memories, sequencer, output register. Depends on mvna_pkg, mvna_if, mvna_unit.
//
// One item is handled at a time. A vertex write is stored as it is taken. A
// clear of all sums sweeps the sum memory one entry per cycle, and the same
// sweep runs after reset; no item is taken meanwhile. A triangle reads its
// three positions, forms the edges, reduces them, forms the cross product one
// component at a time, runs the scaler and then does a read-modify-write on
// the sums of its three corners. The scaler shifts all components until every
// magnitude is below 2^30, sums the squares, takes a bit-serial square root
// and divides each component. A normal read fetches the sum, runs the scaler
// and loads the result register. The result register lets the next item be
// taken while a result waits for its transfer.
`default_nettype none

module mesh_vertex_normal_accumulator
  import mvna_pkg::*;
#(
  parameter int unsigned VERTEX_DEPTH = VERTEX_DEPTH_DEF,
  parameter int unsigned COORD_BITS   = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mvna_in_if.sink     in_i,
  mvna_out_if.source  out_o
);

  localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = CB + 1;
  localparam int unsigned RW = (EW < MAG_BITS + 1) ? EW : MAG_BITS + 1;
  localparam int unsigned CW = 2 * RW + 1;
  localparam int unsigned UW = (CW > SUM_W) ? CW : SUM_W;

  top_state_e state_q, state_d;
  in_t        item_q;
  logic [1:0] cnt_q;
  logic [AW-1:0] clr_q;

  // Memories
  logic [2:0][CB-1:0]    pos_mem [VERTEX_DEPTH];
  logic [2:0][CB-1:0]    pos_rdata_q, pos_wdata, va_q, vb_q;
  logic [AW-1:0]         pos_raddr;
  logic                  pos_we;
  logic [2:0][SUM_W-1:0] sum_mem [VERTEX_DEPTH];
  logic [2:0][SUM_W-1:0] sum_rdata_q, sum_wdata, acc_wdata;
  logic [AW-1:0]         sum_raddr, sum_waddr;
  logic                  sum_we;

  // Edge and cross-product datapath
  logic [EW-1:0]         em_q [6];
  logic [5:0]            eneg_q;
  logic signed [RW-1:0]  es [6];
  logic signed [RW-1:0]  m1a, m1b, m2a, m2b;
  logic signed [2*RW-1:0] p1, p2;
  logic signed [CW-1:0]  cross_q [3];
  logic signed [EW-1:0]  ediff [6];
  logic                  e_over;

  logic [2:0][NRM_W-1:0] n_q;
  logic signed [UW-1:0]  uvec [3];
  logic                  ustart;
  unit_res_t             ures;

  logic                  in_fire, idx_ok, tri_ok, out_load;
  logic [IDX_W-1:0]      corner;
  out_t                  out_q;
  logic                  out_valid_q;

  assign in_fire = in_i.valid && in_i.ready;
  assign idx_ok  = 32'(item_q.vertex_index) < 32'(VERTEX_DEPTH);
  assign tri_ok  = (32'(in_i.data.corner_a) < 32'(VERTEX_DEPTH)) &&
                   (32'(in_i.data.corner_b) < 32'(VERTEX_DEPTH)) &&
                   (32'(in_i.data.corner_c) < 32'(VERTEX_DEPTH));
  assign out_load = !out_valid_q || out_o.ready;

  // Coordinates: keep the low COORD_BITS of each field, zero above POS_W
  always_comb begin
    for (int b = 0; b < CB; b++) begin
      pos_wdata[0][b] = (b < POS_W) ? in_i.data.pos_x[b % POS_W] : 1'b0;
      pos_wdata[1][b] = (b < POS_W) ? in_i.data.pos_y[b % POS_W] : 1'b0;
      pos_wdata[2][b] = (b < POS_W) ? in_i.data.pos_z[b % POS_W] : 1'b0;
    end
  end
  assign pos_we = in_fire && (in_i.data.kind == KIND_WRITE) &&
                  (32'(in_i.data.vertex_index) < 32'(VERTEX_DEPTH));

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[AW'(in_i.data.vertex_index)] <= pos_wdata;
    pos_rdata_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rdata_q <= sum_mem[sum_raddr];
  end

  // Corner in hand for the accumulate pass
  always_comb begin
    case (cnt_q)
      2'd0:    corner = item_q.corner_a;
      2'd1:    corner = item_q.corner_b;
      default: corner = item_q.corner_c;
    endcase
  end

  // Saturating add of the face normal onto a sum
  always_comb begin
    logic signed [SUM_W:0] s;
    for (int i = 0; i < 3; i++) begin
      s = (SUM_W+1)'($signed(sum_rdata_q[i])) + (SUM_W+1)'($signed(n_q[i]));
      if (s[SUM_W] != s[SUM_W-1]) begin
        acc_wdata[i] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        acc_wdata[i] = s[SUM_W-1:0];
      end
    end
  end

  // Edges B-A and C-A
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ediff[i]   = EW'($signed(vb_q[i])) - EW'($signed(va_q[i]));
      ediff[3+i] = EW'($signed(pos_rdata_q[i])) - EW'($signed(va_q[i]));
    end
    e_over = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if ((em_q[k] >> MAG_BITS) != '0) e_over = 1'b1;
      es[k] = eneg_q[k] ? -$signed(RW'(em_q[k])) : $signed(RW'(em_q[k]));
    end
  end

  // Cross product operands, one component per cycle
  always_comb begin
    case (cnt_q)
      2'd0:    begin m1a = es[1]; m1b = es[5]; m2a = es[2]; m2b = es[4]; end
      2'd1:    begin m1a = es[2]; m1b = es[3]; m2a = es[0]; m2b = es[5]; end
      default: begin m1a = es[0]; m1b = es[4]; m2a = es[1]; m2b = es[3]; end
    endcase
  end
  assign p1 = m1a * m1b;
  assign p2 = m2a * m2b;

  // Scaler operand: face normal, a stored sum, or zero for an out-of-range index
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (state_q == T_USTART) begin
        uvec[i] = UW'(cross_q[i]);
      end else if (idx_ok) begin
        uvec[i] = UW'($signed(sum_rdata_q[i]));
      end else begin
        uvec[i] = '0;
      end
    end
  end

  mvna_unit #(.VW(UW)) u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ustart),
    .vec_i   (uvec),
    .res_o   (ures)
  );

  // Sequencer: next state and memory controls
  always_comb begin
    state_d   = state_q;
    pos_raddr = AW'(item_q.corner_a);
    sum_raddr = AW'(corner);
    sum_we    = 1'b0;
    sum_waddr = AW'(corner);
    sum_wdata = acc_wdata;
    ustart    = 1'b0;
    case (state_q)
      T_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_q;
        sum_wdata = '0;
        if (clr_q == AW'(VERTEX_DEPTH - 1)) state_d = T_IDLE;
      end
      T_IDLE: begin
        if (in_fire) begin
          case (in_i.data.kind)
            KIND_TRIANGLE: if (tri_ok) state_d = T_RDA;
            KIND_READ:     state_d = T_SUM_RD;
            KIND_CLEAR:    state_d = T_CLEAR;
            default:       state_d = T_IDLE;
          endcase
        end
      end
      T_RDA:  state_d = T_RDB;
      T_RDB: begin
        pos_raddr = AW'(item_q.corner_b);
        state_d   = T_RDC;
      end
      T_RDC: begin
        pos_raddr = AW'(item_q.corner_c);
        state_d   = T_EDGE;
      end
      T_EDGE:   state_d = T_REDUCE;
      T_REDUCE: if (!e_over) state_d = T_CROSS;
      T_CROSS:  if (cnt_q == 2'd2) state_d = T_USTART;
      T_USTART: begin
        ustart  = 1'b1;
        state_d = T_UWAIT;
      end
      T_UWAIT:  if (ures.done) state_d = T_ACC_RD;
      T_ACC_RD: state_d = T_ACC_WR;
      T_ACC_WR: begin
        sum_we  = 1'b1;
        state_d = (cnt_q == 2'd2) ? T_IDLE : T_ACC_RD;
      end
      T_SUM_RD: begin
        sum_raddr = AW'(item_q.vertex_index);
        state_d   = T_SUM_START;
      end
      T_SUM_START: begin
        ustart  = 1'b1;
        state_d = T_SUM_WAIT;
      end
      T_SUM_WAIT: if (ures.done) state_d = T_OUT;
      T_OUT:      if (out_load) state_d = T_IDLE;
      default:    state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_CLEAR;
      clr_q       <= '0;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Advance the clearing sweep
      if (state_q == T_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end else begin
        clr_q <= '0;
      end
      // Step counter for cross product and accumulate pass
      if (state_q == T_CROSS || state_q == T_ACC_WR) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (state_q == T_IDLE || state_q == T_UWAIT) begin
        cnt_q <= 2'd0;
      end
      // Hold the result until its transfer
      if (state_q == T_OUT && out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_i.data;
    if (state_q == T_RDB) va_q <= pos_rdata_q;
    if (state_q == T_RDC) vb_q <= pos_rdata_q;
    if (state_q == T_EDGE) begin
      for (int k = 0; k < 6; k++) begin
        em_q[k]   <= ediff[k][EW-1] ? EW'(-ediff[k]) : EW'(ediff[k]);
        eneg_q[k] <= ediff[k][EW-1];
      end
    end
    if (state_q == T_REDUCE && e_over) begin
      for (int k = 0; k < 6; k++) em_q[k] <= em_q[k] >> 1;
    end
    if (state_q == T_CROSS) cross_q[cnt_q] <= CW'(p1) - CW'(p2);
    if (state_q == T_UWAIT && ures.done) n_q <= ures.nrm;
    if (state_q == T_OUT && out_load) begin
      out_q.out_vertex  <= item_q.vertex_index;
      out_q.normal_x    <= ures.nrm[0];
      out_q.normal_y    <= ures.nrm[1];
      out_q.normal_z    <= ures.nrm[2];
      out_q.zero_length <= ures.zero;
    end
  end

  assign in_i.ready  = (state_q == T_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // The scaler only finishes while the sequencer waits for it
  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ures.done |-> (state_q == T_UWAIT || state_q == T_SUM_WAIT))
    else $error("scaler finished outside a wait state");

  // A clear transfer starts the sweep
  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.data.kind == KIND_CLEAR) |=> (state_q == T_CLEAR && clr_q == '0))
    else $error("clear did not start a sweep");

  // Reported components stay within unit range
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(out_q.normal_x) <= 16'sd16384 &&
                     $signed(out_q.normal_x) >= -16'sd16384 &&
                     $signed(out_q.normal_y) <= 16'sd16384 &&
                     $signed(out_q.normal_y) >= -16'sd16384 &&
                     $signed(out_q.normal_z) <= 16'sd16384 &&
                     $signed(out_q.normal_z) >= -16'sd16384))
    else $error("normal component out of range");

  // A zero-length result carries zero components
  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.zero_length) |->
      (out_q.normal_x == '0 && out_q.normal_y == '0 && out_q.normal_z == '0))
    else $error("zero-length result with nonzero components");

endmodule

`default_nettype wire
